// File: src/kmd_pkg.sv
package kmd_pkg;

    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 16;

    // lanes never exceed the eight row bits of an item
    localparam int ROW_LANES = (MAX_ROWS < 8) ? MAX_ROWS : 8;
    // columns never exceed the sixteen codes of the column field
    localparam int COL_DEPTH = (MAX_COLS < 16) ? MAX_COLS : 16;
    localparam int COL_AW    = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
    localparam int ENTRY_W   = 8;
    localparam int WORD_W    = ROW_LANES * ENTRY_W;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [ENTRY_W-1:0] ENTRY_IDLE      = 8'h00;
    localparam logic [ENTRY_W-1:0] ENTRY_DEBOUNCED = 8'h80;

    localparam logic [6:0] RST_DEBOUNCE_MS = 7'd10;
    localparam logic [3:0] RST_ROWS_IN_USE = 4'd8;
    localparam logic [4:0] RST_COLS_IN_USE = 5'd16;

    typedef enum logic [1:0] {
        REG_DEBOUNCE_ENABLE,
        REG_DEBOUNCE_MS,
        REG_ROWS_IN_USE,
        REG_COLS_IN_USE
    } t_reg_idx;

    typedef struct packed {
        logic [3:0] column_index;
        logic [7:0] row_levels;
        logic [6:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0] column_echo;
        logic [7:0] pressed_rows;
    } t_out_item;

    typedef struct packed {
        logic       col_live;
        logic       debounce_enable;
        logic [6:0] debounce_ms;
        logic [6:0] now_ms;
    } t_lane_ctl;

    typedef struct packed {
        logic              en;
        logic [COL_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_store_wr;

endpackage

// File: src/kmd_lane.sv
module kmd_lane (
    input  kmd_pkg::t_lane_ctl            i_ctl,
    input  logic                          i_row_live,
    input  logic                          i_pressed,
    input  logic [kmd_pkg::ENTRY_W-1:0]   i_entry,
    output logic [kmd_pkg::ENTRY_W-1:0]   o_entry,
    output logic                          o_report
);

    logic [6:0] elapsed;

    // time held, modulo 128
    assign elapsed = i_ctl.now_ms - i_entry[6:0];

    always_comb begin
        o_entry  = i_entry;
        o_report = 1'b0;
        if (!(i_ctl.col_live && i_row_live)) begin
            o_report = 1'b0;
        end else if (!i_ctl.debounce_enable) begin
            o_report = i_pressed;
        end else if (!i_pressed) begin
            o_entry = kmd_pkg::ENTRY_IDLE;
        end else if (i_entry[kmd_pkg::ENTRY_W-1]) begin
            o_report = 1'b1;
        end else if (i_entry == kmd_pkg::ENTRY_IDLE) begin
            o_entry = {1'b0, i_ctl.now_ms};
        end else if (elapsed > i_ctl.debounce_ms) begin
            o_entry  = kmd_pkg::ENTRY_DEBOUNCED;
            o_report = 1'b1;
        end
    end

endmodule

// File: src/kmd_store.sv
module kmd_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [kmd_pkg::COL_AW-1:0]    i_rd_addr,
    input  kmd_pkg::t_store_wr            i_wr,
    output logic [kmd_pkg::WORD_W-1:0]    o_rd_word
);

    logic [kmd_pkg::WORD_W-1:0]    r_mem [kmd_pkg::COL_DEPTH];
    logic [kmd_pkg::COL_DEPTH-1:0] r_valid;
    logic [kmd_pkg::WORD_W-1:0]    r_rd_data;
    logic [kmd_pkg::COL_AW-1:0]    r_rd_addr;
    logic                          r_rd_valid;
    logic                          r_fwd_en;
    logic [kmd_pkg::COL_AW-1:0]    r_fwd_addr;
    logic [kmd_pkg::WORD_W-1:0]    r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    // per-column valid bits stand in for clearing the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd_en   <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
                r_fwd_en           <= 1'b1;
            end
        end
    end

    // the last write always holds the newest word of its column
    always_comb begin
        if (r_fwd_en && (r_fwd_addr == r_rd_addr)) begin
            o_rd_word = r_fwd_data;
        end else if (r_rd_valid) begin
            o_rd_word = r_rd_data;
        end else begin
            o_rd_word = '0;
        end
    end

endmodule

// File: src/key_matrix_debouncer_unit.sv
// an accepted item passes the lane stage register and then the output register to o_out_item
// throughput: one item per cycle unless the output stalls, set by the read-modify-write of one
//   column word (read on acceptance, eight row lanes, write-back when the item leaves the lanes)
// reset: i_rst_n synchronous, active low; clears the pipeline, restores the registers
//   and marks every column of the key store idle at once, with no clearing pass
module key_matrix_debouncer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // scan input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  kmd_pkg::t_in_item             i_in_item,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output kmd_pkg::t_out_item            o_out_item,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmd_pkg::APB_AW-1:0]    paddr,
    input  logic [kmd_pkg::APB_DW-1:0]    pwdata,
    output logic [kmd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // configuration registers
    logic       r_debounce_enable;
    logic [6:0] r_debounce_ms;
    logic [3:0] r_rows_in_use;
    logic [4:0] r_cols_in_use;

    // lane stage: the item whose column word is being read back
    logic                r_s1_valid;
    kmd_pkg::t_in_item   r_s1_item;

    // output register
    logic                r_out_valid;
    kmd_pkg::t_out_item  r_out_item;

    logic                          s1_adv;
    logic                          in_acc;
    logic                          apb_wr;
    logic                          col_live;
    logic [kmd_pkg::WORD_W-1:0]    rd_word;
    logic [kmd_pkg::WORD_W-1:0]    new_word;
    logic [kmd_pkg::ROW_LANES-1:0] report;
    logic [7:0]                    n_pressed;
    kmd_pkg::t_lane_ctl            lane_ctl;
    kmd_pkg::t_store_wr            store_wr;

    // ---------------------------------------------------------------
    // register port: writes complete in the access phase, no wait states
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_enable <= 1'b0;
            r_debounce_ms     <= kmd_pkg::RST_DEBOUNCE_MS;
            r_rows_in_use     <= kmd_pkg::RST_ROWS_IN_USE;
            r_cols_in_use     <= kmd_pkg::RST_COLS_IN_USE;
        end else if (apb_wr) begin
            case (kmd_pkg::t_reg_idx'(paddr[3:2]))
                kmd_pkg::REG_DEBOUNCE_ENABLE: r_debounce_enable <= pwdata[0];
                kmd_pkg::REG_DEBOUNCE_MS:     r_debounce_ms     <= pwdata[6:0];
                kmd_pkg::REG_ROWS_IN_USE:     r_rows_in_use     <= pwdata[3:0];
                kmd_pkg::REG_COLS_IN_USE:     r_cols_in_use     <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (kmd_pkg::t_reg_idx'(paddr[3:2]))
            kmd_pkg::REG_DEBOUNCE_ENABLE: prdata = {31'd0, r_debounce_enable};
            kmd_pkg::REG_DEBOUNCE_MS:     prdata = {25'd0, r_debounce_ms};
            kmd_pkg::REG_ROWS_IN_USE:     prdata = {28'd0, r_rows_in_use};
            kmd_pkg::REG_COLS_IN_USE:     prdata = {27'd0, r_cols_in_use};
            default:                      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: the lane stage moves on whenever the output register
    // is empty or being drained, so a new item enters every cycle
    // ---------------------------------------------------------------
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_out_item.column_echo  <= r_s1_item.column_index;
            r_out_item.pressed_rows <= n_pressed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------------------------------------------------------
    // key store: one word per column, eight stamp bytes per word;
    // read on acceptance, written back when the item leaves the lanes
    // ---------------------------------------------------------------
    kmd_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_in_item.column_index[kmd_pkg::COL_AW-1:0]),
        .i_wr      (store_wr),
        .o_rd_word (rd_word)
    );

    // column beyond the wired count or beyond the store gives all-zero
    assign col_live = ({1'b0, r_s1_item.column_index} < r_cols_in_use) &&
                      (6'(r_s1_item.column_index) < 6'(kmd_pkg::MAX_COLS));

    assign lane_ctl.col_live        = col_live;
    assign lane_ctl.debounce_enable = r_debounce_enable;
    assign lane_ctl.debounce_ms     = r_debounce_ms;
    assign lane_ctl.now_ms          = r_s1_item.now_ms;

    // ---------------------------------------------------------------
    // row lanes: one debounce cell per row, all working on the same column
    // ---------------------------------------------------------------
    for (genvar g = 0; g < kmd_pkg::ROW_LANES; g++) begin : g_lane
        kmd_lane u_lane (
            .i_ctl      (lane_ctl),
            // rows_in_use above eight simply enables every lane
            .i_row_live (4'(g) < r_rows_in_use),
            .i_pressed  (!r_s1_item.row_levels[g]),
            .i_entry    (rd_word[g*kmd_pkg::ENTRY_W +: kmd_pkg::ENTRY_W]),
            .o_entry    (new_word[g*kmd_pkg::ENTRY_W +: kmd_pkg::ENTRY_W]),
            .o_report   (report[g])
        );
    end

    // merge: gather the lane reports into one row mask
    always_comb begin
        n_pressed = '0;
        for (int r = 0; r < kmd_pkg::ROW_LANES; r++) begin
            n_pressed[r] = report[r];
        end
    end

    // state only changes with debounce on and a live column
    assign store_wr.en   = s1_adv && r_debounce_enable && col_live;
    assign store_wr.addr = r_s1_item.column_index[kmd_pkg::COL_AW-1:0];
    assign store_wr.data = new_word;

endmodule

// File: src/kmd_checker.sv
module kmd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  kmd_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // every accepted item has a result on the port once it passes the lane stage and output register
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("accepted item produced no result");

    // nothing pending right after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // register port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("register access stalled");

endmodule

bind key_matrix_debouncer_unit kmd_checker u_kmd_checker (.*);
